FILE: sv/qesm_pkg.sv
package qesm_pkg;

  // wheel bookkeeping
  localparam int WHEELS  = 4;
  localparam int WHEEL_W = 2;
  localparam int N_OUT   = (WHEELS < 4) ? WHEELS : 4;

  // field and register widths
  localparam int TIME_W  = 32;
  localparam int SCALE_W = 36;
  localparam int MASK_W  = 4;
  localparam int CFG_W   = 36;
  localparam int CFG_IDX_W = 2;

  // divider: one quotient bit per cycle
  localparam int DIV_STEPS = SCALE_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  // register reset values
  localparam logic [TIME_W-1:0]  STALL_TIMEOUT_RST = 32'd100000;
  localparam logic [SCALE_W-1:0] SPEED_SCALE_RST   = 36'd30720000000;
  localparam logic [MASK_W-1:0]  SPEED_MASK_RST    = 4'd0;
  localparam logic [MASK_W-1:0]  DELTA_MASK_RST    = 4'd5;

  // saturation limits
  localparam logic [SCALE_W-1:0] POS_LIMIT = 36'h0_7FFF_FFFF;
  localparam logic [SCALE_W-1:0] NEG_LIMIT = 36'h0_8000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STALL_TIMEOUT = 2'd0,
    REG_SPEED_SCALE   = 2'd1,
    REG_SPEED_MASK    = 2'd2,
    REG_DELTA_MASK    = 2'd3
  } reg_idx_t;

  typedef enum logic {
    OP_EDGE   = 1'b0,
    OP_SAMPLE = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_FWD  = 2'd1,
    DIR_REV  = 2'd2
  } dir_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_EMIT
  } state_t;

endpackage

FILE: sv/qesm_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module qesm_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [qesm_pkg::SCALE_W-1:0]   dividend,
  input  logic [qesm_pkg::TIME_W-1:0]    divisor,
  output logic                           done,
  output logic [qesm_pkg::SCALE_W-1:0]   quotient
);

  logic                             busy;
  logic [qesm_pkg::DIV_CNT_W-1:0]   cnt;
  logic [qesm_pkg::TIME_W-1:0]      dvsr;
  logic [qesm_pkg::TIME_W-1:0]      rem;
  logic [qesm_pkg::SCALE_W-1:0]     acc;
  logic [qesm_pkg::TIME_W:0]        shifted;
  logic [qesm_pkg::TIME_W:0]        diff;
  logic                             ge;
  logic [qesm_pkg::TIME_W-1:0]      rem_next;
  logic [qesm_pkg::SCALE_W-1:0]     acc_next;

  always_comb begin
    shifted  = {rem, acc[qesm_pkg::SCALE_W-1]};
    ge       = shifted >= {1'b0, dvsr};
    diff     = shifted - {1'b0, dvsr};
    rem_next = ge ? diff[qesm_pkg::TIME_W-1:0] : shifted[qesm_pkg::TIME_W-1:0];
    acc_next = {acc[qesm_pkg::SCALE_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == qesm_pkg::DIV_CNT_W'(qesm_pkg::DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    if (start) begin
      acc  <= dividend;
      rem  <= '0;
      dvsr <= divisor;
    end else if (busy) begin
      acc <= acc_next;
      rem <= rem_next;
    end
  end

  assign quotient = acc;

endmodule

FILE: sv/quad_encoder_speed_meter.sv
// Channel   Dir  Handshake           Payload
// in        in   in_valid/in_stall   opcode, wheel, edge_on_b, level_a, level_b, time_us
// out       out  out_valid/out_stall out_wheel, count_delta, speed_q8, last
// cfg       in   cfg_we              cfg_index, cfg_data
//
// An edge transfer updates the wheel state directly; the next item can follow at once.
// A sample runs, for each of the four wheels, a load state, the shared bit-serial
// divider (36 steps of scale / period, then done) and an emit state.
// in_stall is high for the whole sample; the result register lets the next
// wheel's division run while a result waits for out_stall to drop.
// Synchronous reset loads the register defaults and clears all wheel state.
module quad_encoder_speed_meter (
  input  logic                                 clk,
  input  logic                                 rst,
  // item input
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 opcode,
  input  logic [qesm_pkg::WHEEL_W-1:0]         wheel,
  input  logic                                 edge_on_b,
  input  logic                                 level_a,
  input  logic                                 level_b,
  input  logic [qesm_pkg::TIME_W-1:0]          time_us,
  // result output
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [qesm_pkg::WHEEL_W-1:0]         out_wheel,
  output logic signed [31:0]                   count_delta,
  output logic signed [31:0]                   speed_q8,
  output logic                                 last,
  // configuration
  input  logic                                 cfg_we,
  input  logic [qesm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [qesm_pkg::CFG_W-1:0]           cfg_data
);

  // configuration registers
  logic [qesm_pkg::TIME_W-1:0]  stall_timeout_us;
  logic [qesm_pkg::SCALE_W-1:0] speed_scale;
  logic [qesm_pkg::MASK_W-1:0]  speed_sign_mask;
  logic [qesm_pkg::MASK_W-1:0]  delta_sign_mask;

  // per-wheel state
  logic [31:0]                  position_count   [qesm_pkg::WHEELS];
  logic [31:0]                  sampled_count    [qesm_pkg::WHEELS];
  logic [qesm_pkg::TIME_W-1:0]  last_b_edge_time [qesm_pkg::WHEELS];
  logic [qesm_pkg::TIME_W-1:0]  edge_period      [qesm_pkg::WHEELS];
  qesm_pkg::dir_t               moving_reverse   [qesm_pkg::WHEELS];

  // sequencer
  qesm_pkg::state_t             state, state_next;
  logic [qesm_pkg::WHEEL_W-1:0] idx;
  logic [qesm_pkg::TIME_W-1:0]  sample_time;
  logic [31:0]                  delta_hold;
  logic                         neg_hold;
  logic                         zero_hold;

  // shared addressing and per-wheel reads
  logic [qesm_pkg::WHEEL_W-1:0] addr;
  logic [31:0]                  pos_rd;
  logic [qesm_pkg::TIME_W-1:0]  lastb_rd;
  logic [qesm_pkg::TIME_W-1:0]  per_rd;
  qesm_pkg::dir_t               dir_rd;

  logic                         in_xfer;
  logic                         edge_xfer;
  logic                         sample_xfer;
  logic                         edge_up;
  logic                         wheel_ok;
  logic [qesm_pkg::TIME_W-1:0]  elapsed;
  logic                         stalled;
  logic [qesm_pkg::TIME_W-1:0]  per_eff;
  logic [31:0]                  delta_raw;
  logic                         dir_known;
  logic                         neg_calc;
  logic                         div_start;
  logic                         div_done;
  logic [qesm_pkg::SCALE_W-1:0] quotient;
  logic                         out_free;
  logic                         emit;
  logic [31:0]                  speed_calc;
  logic [qesm_pkg::SCALE_W-1:0] mag_sat;

  assign in_stall    = (state != qesm_pkg::ST_IDLE);
  assign in_xfer     = in_valid && !in_stall;
  assign edge_xfer   = in_xfer && (opcode == qesm_pkg::OP_EDGE);
  assign sample_xfer = in_xfer && (opcode == qesm_pkg::OP_SAMPLE);
  assign wheel_ok    = 32'(wheel) < qesm_pkg::WHEELS;

  // one read address: the edge's wheel when idle, the sample index otherwise
  assign addr     = (state == qesm_pkg::ST_IDLE) ? wheel : idx;
  assign pos_rd   = position_count[addr];
  assign lastb_rd = last_b_edge_time[addr];
  assign per_rd   = edge_period[addr];
  assign dir_rd   = moving_reverse[addr];

  // A edge: unequal levels count up; B edge: equal levels count up
  assign edge_up = edge_on_b ? (level_a == level_b) : (level_a != level_b);

  // stall test and speed sign, evaluated in the load cycle
  always_comb begin
    elapsed   = sample_time - lastb_rd;
    stalled   = elapsed > stall_timeout_us;
    per_eff   = stalled ? '0 : per_rd;
    delta_raw = pos_rd - sampled_count[addr];
    dir_known = (dir_rd == qesm_pkg::DIR_FWD) || (dir_rd == qesm_pkg::DIR_REV);
    neg_calc  = (dir_rd == qesm_pkg::DIR_REV) ^ speed_sign_mask[idx];
  end

  assign div_start = (state == qesm_pkg::ST_LOAD);
  assign out_free  = !out_valid || !out_stall;
  assign emit      = (state == qesm_pkg::ST_EMIT) && out_free;

  qesm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (speed_scale),
    .divisor  (per_eff),
    .done     (div_done),
    .quotient (quotient)
  );

  // saturate the magnitude, then apply the sign
  always_comb begin
    if (neg_hold) begin
      mag_sat = (quotient > qesm_pkg::NEG_LIMIT) ? qesm_pkg::NEG_LIMIT : quotient;
    end else begin
      mag_sat = (quotient > qesm_pkg::POS_LIMIT) ? qesm_pkg::POS_LIMIT : quotient;
    end
    if (zero_hold) begin
      speed_calc = '0;
    end else if (neg_hold) begin
      speed_calc = 32'd0 - mag_sat[31:0];
    end else begin
      speed_calc = mag_sat[31:0];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= qesm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      qesm_pkg::ST_IDLE: begin
        if (sample_xfer) state_next = qesm_pkg::ST_LOAD;
      end
      qesm_pkg::ST_LOAD: begin
        state_next = qesm_pkg::ST_DIV;
      end
      qesm_pkg::ST_DIV: begin
        if (div_done) state_next = qesm_pkg::ST_EMIT;
      end
      qesm_pkg::ST_EMIT: begin
        if (out_free) begin
          if (32'(idx) == qesm_pkg::N_OUT - 1) state_next = qesm_pkg::ST_IDLE;
          else state_next = qesm_pkg::ST_LOAD;
        end
      end
      default: state_next = qesm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (sample_xfer) begin
      idx <= '0;
    end else if (emit) begin
      idx <= idx + 1'b1;
    end
  end

  // per-wheel working values
  always_ff @(posedge clk) begin
    if (sample_xfer) sample_time <= time_us;
    if (state == qesm_pkg::ST_LOAD) begin
      delta_hold <= delta_sign_mask[idx] ? (32'd0 - delta_raw) : delta_raw;
      neg_hold   <= neg_calc;
      zero_hold  <= (per_eff == '0) || !dir_known;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      stall_timeout_us <= qesm_pkg::STALL_TIMEOUT_RST;
      speed_scale      <= qesm_pkg::SPEED_SCALE_RST;
      speed_sign_mask  <= qesm_pkg::SPEED_MASK_RST;
      delta_sign_mask  <= qesm_pkg::DELTA_MASK_RST;
    end else if (cfg_we) begin
      unique case (qesm_pkg::reg_idx_t'(cfg_index))
        qesm_pkg::REG_STALL_TIMEOUT: stall_timeout_us <= cfg_data[qesm_pkg::TIME_W-1:0];
        qesm_pkg::REG_SPEED_SCALE:   speed_scale      <= cfg_data[qesm_pkg::SCALE_W-1:0];
        qesm_pkg::REG_SPEED_MASK:    speed_sign_mask  <= cfg_data[qesm_pkg::MASK_W-1:0];
        qesm_pkg::REG_DELTA_MASK:    delta_sign_mask  <= cfg_data[qesm_pkg::MASK_W-1:0];
        default: ;
      endcase
    end
  end

  // wheel state: edges update it when idle, samples clear stale periods
  // and snapshot the count
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < qesm_pkg::WHEELS; i++) begin
        position_count[i]   <= '0;
        sampled_count[i]    <= '0;
        last_b_edge_time[i] <= '0;
        edge_period[i]      <= '0;
        moving_reverse[i]   <= qesm_pkg::DIR_NONE;
      end
    end else if (edge_xfer && wheel_ok) begin
      if (edge_on_b) begin
        edge_period[addr]      <= time_us - lastb_rd;
        last_b_edge_time[addr] <= time_us;
      end
      if (edge_up) begin
        position_count[addr] <= pos_rd + 32'd1;
        moving_reverse[addr] <= qesm_pkg::DIR_FWD;
      end else begin
        position_count[addr] <= pos_rd - 32'd1;
        moving_reverse[addr] <= qesm_pkg::DIR_REV;
      end
    end else if (state == qesm_pkg::ST_LOAD) begin
      if (stalled) edge_period[addr] <= '0;
      sampled_count[addr] <= pos_rd;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_wheel   <= idx;
      count_delta <= delta_hold;
      speed_q8    <= speed_calc;
      last        <= (32'(idx) == qesm_pkg::N_OUT - 1);
    end
  end

endmodule

FILE: sim/quad_encoder_speed_meter_tb.sv
`timescale 1ns / 100ps

module quad_encoder_speed_meter_tb;

  // Generous watchdog limit for a clean run.
  localparam int CYCLE_LIMIT = 600000;
  // Cycles to let pass after the last report before touching registers.
  localparam int SETTLE_CYCLES = 8;
  // Quiet window at the end so stray reports are caught.
  localparam int TAIL_CYCLES = 200;

  logic                            clk;
  logic                            rst;
  logic                            in_valid;
  logic                            in_stall;
  logic                            opcode;
  logic [qesm_pkg::WHEEL_W-1:0]    wheel;
  logic                            edge_on_b;
  logic                            level_a;
  logic                            level_b;
  logic [qesm_pkg::TIME_W-1:0]     time_us;
  logic                            out_valid;
  logic                            out_stall;
  logic [qesm_pkg::WHEEL_W-1:0]    out_wheel;
  logic signed [31:0]              count_delta;
  logic signed [31:0]              speed_q8;
  logic                            last;
  logic                            cfg_we;
  logic [qesm_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [qesm_pkg::CFG_W-1:0]      cfg_data;

  quad_encoder_speed_meter dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .opcode     (opcode),
    .wheel      (wheel),
    .edge_on_b  (edge_on_b),
    .level_a    (level_a),
    .level_b    (level_b),
    .time_us    (time_us),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_wheel  (out_wheel),
    .count_delta(count_delta),
    .speed_q8   (speed_q8),
    .last       (last),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ------------------------------------------------------------------
  // Wheel predictor: own copy of the registers and per-wheel state
  // ------------------------------------------------------------------
  typedef struct {
    logic [qesm_pkg::WHEEL_W-1:0] wheel;
    logic [31:0]                  delta;
    logic [31:0]                  speed;
    logic                         last;
  } wheel_report_t;

  wheel_report_t expected_reports[$];

  logic [qesm_pkg::TIME_W-1:0]  cfg_timeout;
  logic [qesm_pkg::SCALE_W-1:0] cfg_scale;
  logic [qesm_pkg::MASK_W-1:0]  cfg_speed_mask;
  logic [qesm_pkg::MASK_W-1:0]  cfg_delta_mask;

  logic [31:0]    position[qesm_pkg::WHEELS];
  logic [31:0]    sampled_position[qesm_pkg::WHEELS];
  logic [31:0]    last_b_time[qesm_pkg::WHEELS];
  logic [31:0]    b_period[qesm_pkg::WHEELS];       // 0 = no speed
  qesm_pkg::dir_t heading[qesm_pkg::WHEELS];

  // Stimulus-side encoder model: channel levels and travel direction per wheel
  logic        enc_a[qesm_pkg::WHEELS];
  logic        enc_b[qesm_pkg::WHEELS];
  bit          enc_rev[qesm_pkg::WHEELS];
  logic [31:0] now_us;

  // Idling control for sender and receiver
  bit no_idle;
  int hold_cycles;
  int rx_left;
  bit rx_level;

  // Bookkeeping
  int errors;
  int items_sent;
  int samples_sent;
  int reports_checked;
  int cfg_writes;
  int cycle_count;

  // speed_scale / period with direction, mask and saturation
  function automatic logic [31:0] speed_for(int w);
    logic [qesm_pkg::SCALE_W-1:0] mag;
    bit neg;
    if (b_period[w] == 32'd0) return 32'd0;
    case (heading[w])
      qesm_pkg::DIR_FWD: neg = 1'b0;
      qesm_pkg::DIR_REV: neg = 1'b1;
      default: return 32'd0;
    endcase
    if (cfg_speed_mask[w]) neg = !neg;
    mag = cfg_scale / {{(qesm_pkg::SCALE_W-32){1'b0}}, b_period[w]};
    if (!neg) return (mag > qesm_pkg::POS_LIMIT) ? 32'h7FFF_FFFF : mag[31:0];
    if (mag > qesm_pkg::NEG_LIMIT) mag = qesm_pkg::NEG_LIMIT;
    return -mag[31:0];
  endfunction

  // Apply one accepted item to the predictor; a sample queues four reports.
  task automatic update_wheels(qesm_pkg::opcode_t op, logic [1:0] w, logic on_b,
                               logic la, logic lb, logic [31:0] t);
    bit up;
    wheel_report_t rep;
    if (op == qesm_pkg::OP_EDGE) begin
      if (on_b) begin
        b_period[w]    = t - last_b_time[w];
        last_b_time[w] = t;
        up = (la == lb);
      end else begin
        up = (la != lb);
      end
      position[w] = up ? position[w] + 32'd1 : position[w] - 32'd1;
      heading[w]  = up ? qesm_pkg::DIR_FWD : qesm_pkg::DIR_REV;
    end else begin
      for (int i = 0; i < qesm_pkg::N_OUT; i++) begin
        rep.wheel = i[qesm_pkg::WHEEL_W-1:0];
        rep.delta = position[i] - sampled_position[i];
        if (cfg_delta_mask[i]) rep.delta = -rep.delta;
        // stopped wheel: period forgotten until the next B edge
        if ((t - last_b_time[i]) > cfg_timeout) b_period[i] = 32'd0;
        rep.speed = speed_for(i);
        rep.last  = (i == qesm_pkg::N_OUT - 1);
        expected_reports.push_back(rep);
        sampled_position[i] = position[i];
      end
    end
  endtask

  // ------------------------------------------------------------------
  // Timing helpers
  // ------------------------------------------------------------------
  // Mostly no gap, some short, a few long.
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  // in_valid is written once per step: lowered only when a gap is inserted.
  task automatic send_item(qesm_pkg::opcode_t op, logic [1:0] w, logic on_b, logic la,
                           logic lb, logic [31:0] t);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    opcode    <= op;
    wheel     <= w;
    edge_on_b <= on_b;
    level_a   <= la;
    level_b   <= lb;
    time_us   <= t;
    do @(posedge clk); while (in_stall);
    update_wheels(op, w, on_b, la, lb, t);
    items_sent++;
    if (op == qesm_pkg::OP_SAMPLE) samples_sent++;
    @(negedge clk);
  endtask

  // Sample requests carry junk in the fields the block ignores.
  task automatic send_sample(logic [31:0] t);
    send_item(qesm_pkg::OP_SAMPLE, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), t);
  endtask

  // Sender pauses until every queued report has arrived, then settles.
  task automatic drain_reports();
    in_valid <= 1'b0;
    while (expected_reports.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Leaves cfg_we high; set_config lowers it after the last write.
  task automatic write_reg(qesm_pkg::reg_idx_t idx, logic [qesm_pkg::CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      qesm_pkg::REG_STALL_TIMEOUT: cfg_timeout    = val[qesm_pkg::TIME_W-1:0];
      qesm_pkg::REG_SPEED_SCALE:   cfg_scale      = val[qesm_pkg::SCALE_W-1:0];
      qesm_pkg::REG_SPEED_MASK:    cfg_speed_mask = val[qesm_pkg::MASK_W-1:0];
      qesm_pkg::REG_DELTA_MASK:    cfg_delta_mask = val[qesm_pkg::MASK_W-1:0];
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk);
  endtask

  task automatic set_config(logic [31:0] tmo, logic [35:0] scl, logic [3:0] smask,
                            logic [3:0] dmask);
    drain_reports();
    write_reg(qesm_pkg::REG_STALL_TIMEOUT, {4'd0, tmo});
    write_reg(qesm_pkg::REG_SPEED_SCALE, scl);
    write_reg(qesm_pkg::REG_SPEED_MASK, {32'd0, smask});
    write_reg(qesm_pkg::REG_DELTA_MASK, {32'd0, dmask});
    cfg_we <= 1'b0;
  endtask

  task automatic random_config();
    logic [31:0] tmo;
    logic [35:0] scl;
    case ($urandom_range(0, 3))
      0:       tmo = 32'd0;
      1:       tmo = $urandom_range(500, 20000);  // stalls show up now and then
      2:       tmo = $urandom;
      default: tmo = 32'hFFFF_FFFF;
    endcase
    case ($urandom_range(0, 3))
      0: scl = '0;
      1: begin
        scl[35:32] = 4'($urandom_range(0, 15));
        scl[31:0]  = $urandom;
      end
      2:       scl = qesm_pkg::SPEED_SCALE_RST;
      default: scl = 36'hF_FFFF_FFFF;
    endcase
    set_config(tmo, scl, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
  endtask

  // ------------------------------------------------------------------
  // Receiver: random stall bursts, plus a counted hold-off on request
  // ------------------------------------------------------------------
  initial begin
    out_stall = 1'b0;
    rx_left   = 0;
    rx_level  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        rx_level = 1'b1;
        rx_left  = 0;
      end else if (no_idle) begin
        rx_level = 1'b0;
      end else if (rx_left > 0) begin
        rx_left--;
      end else begin
        rx_level = !rx_level;
        rx_left  = rx_level ? pick_gap() : $urandom_range(0, 12);
      end
      out_stall <= rx_level;
    end
  end

  // ------------------------------------------------------------------
  // Report checker: every transfer is compared with the oldest prediction
  // ------------------------------------------------------------------
  always @(posedge clk) begin
    wheel_report_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_reports.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: unexpected report wheel=%0d delta=%0d speed=%0d last=%0b",
                   $realtime, out_wheel, count_delta, speed_q8, last);
      end else begin
        want = expected_reports.pop_front();
        reports_checked++;
        if (out_wheel !== want.wheel || count_delta !== want.delta ||
            speed_q8 !== want.speed || last !== want.last) begin
          errors++;
          if (errors <= 10)
            $display({"%0t: mismatch exp wheel=%0d delta=%0d speed=%0d last=%0b",
                      " | got wheel=%0d delta=%0d speed=%0d last=%0b"},
                     $realtime, want.wheel, $signed(want.delta), $signed(want.speed),
                     want.last, out_wheel, count_delta, speed_q8, last);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d reports still pending", $realtime,
               expected_reports.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------
  // Sample straight after reset: zero deltas, no direction so zero speed.
  task automatic test_reset_state();
    send_sample(32'd50);
  endtask

  // All eight (channel, level A, level B) combinations across the wheels.
  // First B edge after reset measures from time zero; a repeated B edge at
  // the same timestamp gives a zero period and so zero speed.
  task automatic test_edge_decoding();
    send_item(qesm_pkg::OP_EDGE, 2'd0, 1'b0, 1'b1, 1'b0, 32'd100);  // A, unequal: up
    send_item(qesm_pkg::OP_EDGE, 2'd0, 1'b0, 1'b1, 1'b1, 32'd200);  // A, equal: down
    send_item(qesm_pkg::OP_EDGE, 2'd1, 1'b1, 1'b0, 1'b0, 32'd700);  // B, equal: up
    send_item(qesm_pkg::OP_EDGE, 2'd1, 1'b1, 1'b0, 1'b1, 32'd900);  // B, unequal: down
    send_item(qesm_pkg::OP_EDGE, 2'd2, 1'b0, 1'b0, 1'b1, 32'd300);
    send_item(qesm_pkg::OP_EDGE, 2'd2, 1'b0, 1'b0, 1'b0, 32'd350);
    send_item(qesm_pkg::OP_EDGE, 2'd3, 1'b1, 1'b1, 1'b1, 32'd400);
    send_item(qesm_pkg::OP_EDGE, 2'd3, 1'b1, 1'b1, 1'b0, 32'd400);  // zero period
    send_item(qesm_pkg::OP_EDGE, 2'd0, 1'b1, 1'b1, 1'b1, 32'd950);
    send_sample(32'd1000);
  endtask

  // Period of one tick with full-scale numerators: saturation both ways,
  // timestamp wrap, sign masks, then a zero numerator.
  task automatic test_speed_extremes();
    set_config(32'hFFFF_FFFF, 36'hF_FFFF_FFFF, 4'b1010, 4'hF);
    send_item(qesm_pkg::OP_EDGE, 2'd0, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFF0);
    send_item(qesm_pkg::OP_EDGE, 2'd0, 1'b1, 1'b0, 1'b0, 32'hFFFF_FFF1);
    send_item(qesm_pkg::OP_EDGE, 2'd1, 1'b1, 1'b1, 1'b0, 32'd5);
    send_item(qesm_pkg::OP_EDGE, 2'd1, 1'b1, 1'b0, 1'b1, 32'd6);
    send_item(qesm_pkg::OP_EDGE, 2'd2, 1'b1, 1'b1, 1'b0, 32'hFFFF_FFF8);
    send_item(qesm_pkg::OP_EDGE, 2'd2, 1'b1, 1'b0, 1'b1, 32'd8);   // period across wrap
    send_item(qesm_pkg::OP_EDGE, 2'd3, 1'b1, 1'b1, 1'b1, 32'd7);
    send_sample(32'hFFFF_FFFF);
    // magnitude exactly 2^31: clipped forward, exact in reverse
    set_config(32'hFFFF_FFFF, 36'h0_8000_0000, 4'b0000, 4'h0);
    send_sample(32'd0);
    set_config(32'hFFFF_FFFF, 36'd0, 4'hF, 4'h0);
    send_sample(32'd10);
  endtask

  // Zero timeout: any elapsed time stops a wheel; only a new B edge revives it.
  task automatic test_stall_timeout();
    set_config(32'd0, qesm_pkg::SPEED_SCALE_RST, 4'hF, qesm_pkg::DELTA_MASK_RST);
    send_sample(32'd1);
    send_item(qesm_pkg::OP_EDGE, 2'd0, 1'b1, 1'b0, 1'b0, 32'd100);
    send_sample(32'd100);
  endtask

  // Mostly legal Gray-code travel with random timing; some noise edges,
  // duplicate timestamps and large time jumps.
  task automatic test_random_traffic(int n_items, int sample_pct);
    int r;
    int w;
    logic on_b;
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(1, 100) <= sample_pct) begin
        now_us += $urandom_range(0, 5000);
        send_sample(now_us);
      end else begin
        w = $urandom_range(0, qesm_pkg::WHEELS - 1);
        r = $urandom_range(0, 99);
        if (r < 3) now_us += $urandom;
        else if (r >= 8) now_us += $urandom_range(1, 3000);
        if ($urandom_range(0, 9) == 0) begin
          // noise: arbitrary channel and levels
          on_b     = 1'($urandom_range(0, 1));
          enc_a[w] = 1'($urandom_range(0, 1));
          enc_b[w] = 1'($urandom_range(0, 1));
        end else begin
          if ($urandom_range(0, 9) == 0) enc_rev[w] = !enc_rev[w];
          // forward: A toggles when levels match, B otherwise; reverse swaps
          on_b = (enc_a[w] == enc_b[w]) ? enc_rev[w] : !enc_rev[w];
          if (on_b) enc_b[w] = !enc_b[w];
          else enc_a[w] = !enc_a[w];
        end
        send_item(qesm_pkg::OP_EDGE, w[1:0], on_b, enc_a[w], enc_b[w], now_us);
      end
    end
  endtask

  // Receiver holds off while the sender keeps offering: the block fills,
  // in_stall rises, and everything resumes when the hold-off expires.
  task automatic test_backpressure();
    hold_cycles = 400;
    send_sample(now_us);
    test_random_traffic(11, 30);
  endtask

  // ------------------------------------------------------------------
  // Main sequence
  // ------------------------------------------------------------------
  initial begin
    clk         = 1'b0;
    rst         = 1'b1;
    in_valid    = 1'b0;
    opcode      = qesm_pkg::OP_EDGE;
    wheel       = '0;
    edge_on_b   = 1'b0;
    level_a     = 1'b0;
    level_b     = 1'b0;
    time_us     = '0;
    cfg_we      = 1'b0;
    cfg_index   = qesm_pkg::REG_STALL_TIMEOUT;
    cfg_data    = '0;
    no_idle     = 1'b0;
    hold_cycles = 0;
    errors      = 0;
    items_sent  = 0;
    samples_sent = 0;
    reports_checked = 0;
    cfg_writes  = 0;
    cycle_count = 0;
    now_us      = 32'd2000;
    cfg_timeout    = qesm_pkg::STALL_TIMEOUT_RST;
    cfg_scale      = qesm_pkg::SPEED_SCALE_RST;
    cfg_speed_mask = qesm_pkg::SPEED_MASK_RST;
    cfg_delta_mask = qesm_pkg::DELTA_MASK_RST;
    for (int w = 0; w < qesm_pkg::WHEELS; w++) begin
      position[w]         = '0;
      sampled_position[w] = '0;
      last_b_time[w]      = '0;
      b_period[w]         = '0;
      heading[w]          = qesm_pkg::DIR_NONE;
      enc_a[w]            = 1'b0;
      enc_b[w]            = 1'b0;
      enc_rev[w]          = 1'b0;
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_reset_state();
    test_edge_decoding();
    test_speed_extremes();
    test_stall_timeout();

    // stretch with no idling on either side
    set_config(qesm_pkg::STALL_TIMEOUT_RST, qesm_pkg::SPEED_SCALE_RST,
               qesm_pkg::SPEED_MASK_RST, qesm_pkg::DELTA_MASK_RST);
    no_idle = 1'b1;
    test_random_traffic(40, 15);
    drain_reports();
    no_idle = 1'b0;

    random_config();
    test_random_traffic(70, 15);
    drain_reports();

    test_backpressure();

    random_config();
    test_random_traffic(70, 20);

    set_config(32'hFFFF_FFFF, 36'hF_FFFF_FFFF, 4'hF, 4'h0);
    test_random_traffic(50, 15);

    drain_reports();
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Covered %0d transfers (%0d samples), %0d wheel reports checked,",
             items_sent, samples_sent, reports_checked);
    $display("%0d register writes incl. timeout/scale/mask extremes and a long hold-off.",
             cfg_writes);
    if (errors == 0 && expected_reports.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d errors, %0d reports missing", errors, expected_reports.size());
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
